FILE: src/pwif_pkg.sv
// Package for the plane-wave incident field block: widths, register
// indexes, CORDIC constants and the arctangent table. No dependencies.
`default_nettype none
package pwif_pkg;
    localparam int SINCOS_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POL_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POL_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POL_Z       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE = 3'd6;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [23:0] centroid_x;
        logic signed [23:0] centroid_y;
        logic signed [23:0] centroid_z;
    } t_in_item;

    typedef struct packed {
        logic               lit;
        logic signed [15:0] field_x_re;
        logic signed [15:0] field_x_im;
        logic signed [15:0] field_y_re;
        logic signed [15:0] field_y_im;
        logic signed [15:0] field_z_re;
        logic signed [15:0] field_z_im;
    } t_out_item;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) return 16'sh7fff;
        if (v < -34'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction
endpackage
`default_nettype wire

FILE: src/pwif_if.sv
// Valid/ready stream channel for triangle and field beats.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface pwif_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/plane_wave_incident_field.sv
// Plane-wave incident field: fully pipelined, one triangle per cycle while
// the output is not stalled. Output valid rises once the accepted beat has
// passed two dot-product stages, two phase multiply stages, a CORDIC entry
// register, SINCOS_STAGES rotations (capped at the table length), a rounding
// stage, a field multiply stage and the output register. The whole pipeline
// advances when the output register is empty or being taken, so a stall
// holds every stage. Configuration must be written only while idle; the
// block itself does not enforce it. Uses pwif_pkg and pwif_if.
`default_nettype none
module plane_wave_incident_field
    import pwif_pkg::*;
#(
    parameter int SINCOS_STAGES = SINCOS_STAGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    pwif_if.sink                       s_in,
    pwif_if.source                     m_out
);
    localparam int NS = (SINCOS_STAGES < ATAN_ENTRIES) ? SINCOS_STAGES : ATAN_ENTRIES;
    localparam int NV = NS + 7;   // valid stages before output register

    logic signed [15:0] r_dir [3];
    logic signed [15:0] r_pol [3];
    logic        [23:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir[0] <= '0; r_dir[1] <= '0; r_dir[2] <= -16'sd16384;
            r_pol[0] <= 16'sd16384; r_pol[1] <= '0; r_pol[2] <= '0;
            r_scale  <= 24'd282624;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIR_X:       r_dir[0] <= i_cfg_data[15:0];
                REG_DIR_Y:       r_dir[1] <= i_cfg_data[15:0];
                REG_DIR_Z:       r_dir[2] <= i_cfg_data[15:0];
                REG_POL_X:       r_pol[0] <= i_cfg_data[15:0];
                REG_POL_Y:       r_pol[1] <= i_cfg_data[15:0];
                REG_POL_Z:       r_pol[2] <= i_cfg_data[15:0];
                REG_PHASE_SCALE: r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_ov;
    t_out_item r_out;
    logic [NV-1:0] r_v;
    assign adv = !r_ov || m_out.ready;
    assign s_in.ready = adv;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v  <= {r_v[NV-2:0], s_in.valid};
            r_ov <= r_v[NV-1];
        end
    end

    // stage 1: products
    logic signed [31:0] r_lp [3];
    logic signed [39:0] r_pp [3];
    // stage 2: sums
    logic signed [33:0] r_ldot;
    logic signed [41:0] r_pdot;
    // stage 3/4: phase multiply split in two partial products
    logic signed [41:0] r_pd3;
    logic [35:0] r_plo36;
    logic [31:0] r_phase;
    logic        r_lit [NV];
    // cordic
    logic signed [33:0] r_cx [NS+1];
    logic signed [33:0] r_cy [NS+1];
    logic signed [33:0] r_cz [NS+1];
    logic               r_fl [NS+1];
    logic signed [15:0] r_c, r_s;
    logic signed [33:0] r_f [6];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0: begin
                        r_lp[k] <= s_in.data.normal_x * r_dir[k];
                        r_pp[k] <= r_dir[k] * s_in.data.centroid_x;
                    end
                    1: begin
                        r_lp[k] <= s_in.data.normal_y * r_dir[k];
                        r_pp[k] <= r_dir[k] * s_in.data.centroid_y;
                    end
                    default: begin
                        r_lp[k] <= s_in.data.normal_z * r_dir[k];
                        r_pp[k] <= r_dir[k] * s_in.data.centroid_z;
                    end
                endcase
            end
            r_ldot <= 34'(r_lp[0]) + 34'(r_lp[1]) + 34'(r_lp[2]);
            r_pdot <= 42'(r_pp[0]) + 42'(r_pp[1]) + 42'(r_pp[2]);
            r_lit[0] <= 1'b0;
            r_lit[1] <= 1'b0;
            r_lit[2] <= r_ldot[33];
            // low 12 bits of pdot times scale; only bits 10.. of the sum matter
            r_plo36 <= {24'd0, r_pdot[11:0]} * {12'd0, r_scale};
            r_pd3   <= r_pdot;
            r_lit[3] <= r_lit[2];
            // phase = (pdot*scale)[41:10]; high part adds pdot[41:12]*scale << 12
            r_phase <= 32'((r_plo36 >> 10)
                       + ({r_pd3[41:12], 12'd0} * {8'd0, r_scale} >> 10));
            for (int i = 4; i < NV; i++) r_lit[i] <= r_lit[i-1];
        end
    end

    // fold and CORDIC entry
    logic [31:0] fold_u;
    logic        fold_f;
    always_comb begin
        logic [31:0] t;
        t = r_phase + 32'h40000000;
        fold_f = t[31];
        fold_u = fold_f ? r_phase + 32'h80000000 : r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0] <= CORDIC_GAIN;
            r_cy[0] <= '0;
            r_cz[0] <= 34'(signed'(fold_u));
            r_fl[0] <= fold_f;
            for (int i = 0; i < NS; i++) begin
                if (!r_cz[i][33]) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - 34'(atan_turns(i));
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + 34'(atan_turns(i));
                end
                r_fl[i+1] <= r_fl[i];
            end
        end
    end

    logic signed [33:0] fx, fy;
    assign fx = r_fl[NS] ? -r_cx[NS] : r_cx[NS];
    assign fy = r_fl[NS] ? -r_cy[NS] : r_cy[NS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c <= 16'((fx + 34'sd32768) >>> 16);
            r_s <= 16'((fy + 34'sd32768) >>> 16);
            for (int k = 0; k < 3; k++) begin
                r_f[2*k]   <= 34'(r_pol[k]) * 34'(r_c);
                r_f[2*k+1] <= 34'(r_pol[k]) * 34'(r_s);
            end
            r_out.lit <= r_lit[NV-1];
            if (r_lit[NV-1]) begin
                r_out.field_x_re <= sat16((r_f[0] + 34'sd8192) >>> 14);
                r_out.field_x_im <= sat16((r_f[1] + 34'sd8192) >>> 14);
                r_out.field_y_re <= sat16((r_f[2] + 34'sd8192) >>> 14);
                r_out.field_y_im <= sat16((r_f[3] + 34'sd8192) >>> 14);
                r_out.field_z_re <= sat16((r_f[4] + 34'sd8192) >>> 14);
                r_out.field_z_im <= sat16((r_f[5] + 34'sd8192) >>> 14);
            end else begin
                r_out.field_x_re <= '0; r_out.field_x_im <= '0;
                r_out.field_y_re <= '0; r_out.field_y_im <= '0;
                r_out.field_z_re <= '0; r_out.field_z_im <= '0;
            end
        end
    end

    // unlit beats leave with all fields zero; checked on x_re, y_im and z_re
    a_unlit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.data.lit) |-> (m_out.data.field_x_re == 16'sd0
            && m_out.data.field_y_im == 16'sd0 && m_out.data.field_z_re == 16'sd0))
        else $error("unlit beat carries a field");
    // a stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.data)))
        else $error("output beat changed under stall");
    // pipeline freezes while stalled
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_in.ready) |=> $stable(r_v))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
